FILE: src/lcgc_pkg.sv
// shared types, codes and reset constants of the level crossing gate controller
`default_nettype none
package lcgc_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned COUNT_W       = 32;

  localparam logic [CFG_W-1:0] WARNING_RST   = 16'd300;
  localparam logic [CFG_W-1:0] MOVE_RST      = 16'd40;
  localparam logic [CFG_W-1:0] OCCUPY_RST    = 16'd150;
  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd100;
  localparam logic [CFG_W-1:0] JAM_EXTRA_RST = 16'd50;
  localparam logic [CFG_W-1:0] REFRESH_RST   = 16'd10;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_DETECT    = 2'd1,
    OP_FAULT_SET = 2'd2,
    OP_FAULT_CLR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_CLEAR   = 2'd0,
    ST_WARNING = 2'd1,
    ST_CLOSED  = 2'd2,
    ST_FAULT   = 2'd3
  } xstate_e;

  typedef enum logic [1:0] {
    POS_UP     = 2'd0,
    POS_DOWN   = 2'd1,
    POS_MOVING = 2'd2
  } gate_pos_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WARNING   = 3'd0,
    CFG_MOVE      = 3'd1,
    CFG_OCCUPY    = 3'd2,
    CFG_TIMEOUT   = 3'd3,
    CFG_JAM_EXTRA = 3'd4,
    CFG_REFRESH   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] warning_ticks;
    logic [CFG_W-1:0] gate_move_ticks;
    logic [CFG_W-1:0] occupy_ticks;
    logic [CFG_W-1:0] gate_timeout_ticks;
    logic [CFG_W-1:0] jam_extra_ticks;
    logic [CFG_W-1:0] refresh_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               track_select;
    logic [STAMP_W-1:0] detect_stamp;
    logic               hold_trains;
  } item_t;

  typedef struct packed {
    xstate_e    cross_state;
    gate_pos_e  gate_now;
    logic       gate_goal;
    logic       fault_flag;
    logic       signal_green;
    logic [1:0] busy_mask;
    logic [1:0] det_valid;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]         crossing_state;
    logic [1:0]         gate_position;
    logic [1:0]         busy_tracks;
    logic               fault_active;
    logic               signal_green;
    logic               line_stopped_echo;
    logic [COUNT_W-1:0] status_seq;
    logic [COUNT_W-1:0] served_count;
    logic               fault_report;
    logic               state_changed;
  } status_t;

endpackage
`default_nettype wire

FILE: src/lcgc_if.sv
// request, status and register write channel interfaces
`default_nettype none
interface lcgc_item_if;
  import lcgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               track_select;
  logic [STAMP_W-1:0] detect_stamp;
  logic               hold_trains;

  modport source (output valid, opcode, track_select, detect_stamp, hold_trains,
                  input ready);
  modport sink   (input valid, opcode, track_select, detect_stamp, hold_trains,
                  output ready);
endinterface

interface lcgc_status_if;
  import lcgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         crossing_state;
  logic [1:0]         gate_position;
  logic [1:0]         busy_tracks;
  logic               fault_active;
  logic               signal_green;
  logic               line_stopped_echo;
  logic [COUNT_W-1:0] status_seq;
  logic [COUNT_W-1:0] served_count;
  logic               fault_report;
  logic               state_changed;

  modport source (output valid, crossing_state, gate_position, busy_tracks, fault_active,
                  signal_green, line_stopped_echo, status_seq, served_count,
                  fault_report, state_changed,
                  input ready);
  modport sink   (input valid, crossing_state, gate_position, busy_tracks, fault_active,
                  signal_green, line_stopped_echo, status_seq, served_count,
                  fault_report, state_changed,
                  output ready);
endinterface

interface lcgc_cfg_if;
  import lcgc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/lcgc_cfg_regs.sv
// timing register file written through the register write channel
`default_nettype none
module lcgc_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  lcgc_cfg_if.sink          cfg_i,
  output lcgc_pkg::cfg_t    cfg_o
);
  import lcgc_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warning_ticks      <= WARNING_RST;
      cfg_q.gate_move_ticks    <= MOVE_RST;
      cfg_q.occupy_ticks       <= OCCUPY_RST;
      cfg_q.gate_timeout_ticks <= TIMEOUT_RST;
      cfg_q.jam_extra_ticks    <= JAM_EXTRA_RST;
      cfg_q.refresh_ticks      <= REFRESH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_WARNING:   cfg_q.warning_ticks      <= cfg_i.data;
        CFG_MOVE:      cfg_q.gate_move_ticks    <= cfg_i.data;
        CFG_OCCUPY:    cfg_q.occupy_ticks       <= cfg_i.data;
        CFG_TIMEOUT:   cfg_q.gate_timeout_ticks <= cfg_i.data;
        CFG_JAM_EXTRA: cfg_q.jam_extra_ticks    <= cfg_i.data;
        CFG_REFRESH:   cfg_q.refresh_ticks      <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/lcgc_step.sv
// next-state and status logic for one request
`default_nettype none
module lcgc_step #(
  parameter int unsigned TIME_BITS = lcgc_pkg::TIME_BITS_DEF
) (
  input  wire lcgc_pkg::item_t           item_i,
  input  wire lcgc_pkg::cfg_t            cfg_i,
  input  wire lcgc_pkg::ctrl_t           ctrl_q_i,
  input  wire logic [TIME_BITS-1:0]      tick_q_i,
  input  wire logic [TIME_BITS-1:0]      det_time_q_i [2],
  input  wire logic [TIME_BITS-1:0]      deadline_q_i,
  input  wire logic [TIME_BITS-1:0]      last_pub_q_i,
  input  wire logic [lcgc_pkg::COUNT_W-1:0] trains_q_i,
  input  wire logic [lcgc_pkg::COUNT_W-1:0] seq_q_i,
  output lcgc_pkg::ctrl_t                ctrl_d_o,
  output logic [TIME_BITS-1:0]           tick_d_o,
  output logic [TIME_BITS-1:0]           det_time_d_o [2],
  output logic [TIME_BITS-1:0]           deadline_d_o,
  output logic [TIME_BITS-1:0]           last_pub_d_o,
  output logic [lcgc_pkg::COUNT_W-1:0]   trains_d_o,
  output logic [lcgc_pkg::COUNT_W-1:0]   seq_d_o,
  output logic                           res_valid_o,
  output lcgc_pkg::status_t              res_o
);
  import lcgc_pkg::*;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] ext16(input logic [CFG_W-1:0] v);
    logic [TIME_BITS+CFG_W-1:0] w;
    w = {{TIME_BITS{1'b0}}, v};
    return w[TIME_BITS-1:0];
  endfunction

  logic [TIME_BITS+STAMP_W-1:0] stamp_ext;
  logic [TIME_BITS-1:0]         track_len;

  assign stamp_ext = {{TIME_BITS{1'b0}}, item_i.detect_stamp};
  assign track_len = sat_add(sat_add(ext16(cfg_i.warning_ticks), ext16(cfg_i.gate_move_ticks)),
                             ext16(cfg_i.occupy_ticks));

  always_comb begin
    logic [TIME_BITS-1:0] tick_n;
    logic [TIME_BITS-1:0] lower_t;
    logic [TIME_BITS-1:0] due_t;
    logic [TIME_BITS-1:0] since_pub;
    logic                 changed;
    logic                 report;
    logic                 coming;
    logic                 lower_req;
    logic                 target;
    logic                 do_cmd;
    logic [1:0]           busy;
    xstate_e              next_st;

    ctrl_d_o     = ctrl_q_i;
    tick_d_o     = tick_q_i;
    det_time_d_o = det_time_q_i;
    deadline_d_o = deadline_q_i;
    last_pub_d_o = last_pub_q_i;
    trains_d_o   = trains_q_i;
    seq_d_o      = seq_q_i;
    res_valid_o  = 1'b0;
    res_o        = '0;
    tick_n       = tick_q_i + TIME_BITS'(1);
    lower_t      = '0;
    due_t        = '0;
    since_pub    = tick_n - last_pub_q_i;
    changed      = 1'b0;
    report       = 1'b0;
    coming       = 1'b0;
    lower_req    = 1'b0;
    target       = 1'b0;
    do_cmd       = 1'b0;
    busy         = 2'b00;
    next_st      = ST_CLEAR;

    case (opcode_e'(item_i.opcode))
      OP_DETECT: begin
        ctrl_d_o.det_valid[item_i.track_select] = 1'b1;
        det_time_d_o[item_i.track_select]       = stamp_ext[TIME_BITS-1:0];
      end
      OP_FAULT_SET: ctrl_d_o.fault_flag = 1'b1;
      OP_FAULT_CLR: ctrl_d_o.fault_flag = 1'b0;
      OP_TICK: begin
        tick_d_o = tick_n;
        // gate travel
        if (ctrl_q_i.gate_now == POS_MOVING) begin
          if (tick_n >= deadline_q_i) begin
            ctrl_d_o.gate_now = ctrl_q_i.gate_goal ? POS_DOWN : POS_UP;
            changed           = 1'b1;
          end else if (ctrl_q_i.fault_flag && ctrl_q_i.cross_state != ST_FAULT) begin
            changed = 1'b1;
          end
        end
        if (ctrl_q_i.fault_flag) begin
          if (ctrl_q_i.cross_state != ST_FAULT) begin
            ctrl_d_o.cross_state  = ST_FAULT;
            ctrl_d_o.signal_green = 1'b0;
            changed               = 1'b1;
            report                = 1'b1;
          end
        end else begin
          for (int t = 0; t < 2; t++) begin
            if (ctrl_q_i.det_valid[t]) begin
              lower_t = sat_add(det_time_q_i[t], ext16(cfg_i.warning_ticks));
              due_t   = sat_add(lower_t, ext16(cfg_i.gate_move_ticks));
              if (tick_n >= sat_add(det_time_q_i[t], track_len)) begin
                ctrl_d_o.det_valid[t] = 1'b0;
                changed               = 1'b1;
              end else begin
                coming = 1'b1;
                if (tick_n >= lower_t) begin
                  lower_req = 1'b1;
                end
                if (tick_n >= due_t && ctrl_d_o.gate_now == POS_DOWN) begin
                  if (!ctrl_q_i.busy_mask[t]) begin
                    trains_d_o = trains_d_o + COUNT_W'(1);
                  end
                  busy[t] = 1'b1;
                end
              end
            end
          end
          if (busy != ctrl_q_i.busy_mask) begin
            ctrl_d_o.busy_mask = busy;
            changed            = 1'b1;
          end
          if (lower_req || (coming && ctrl_q_i.gate_goal)) begin
            target = 1'b1;
            do_cmd = 1'b1;
          end else if (!coming) begin
            target = 1'b0;
            do_cmd = 1'b1;
          end
          if (do_cmd && ctrl_q_i.gate_goal != target) begin
            ctrl_d_o.gate_goal = target;
            ctrl_d_o.gate_now  = POS_MOVING;
            deadline_d_o       = sat_add(tick_n, ext16(cfg_i.gate_move_ticks));
          end
          if (coming) begin
            next_st = (ctrl_d_o.gate_now == POS_DOWN) ? ST_CLOSED : ST_WARNING;
          end else begin
            next_st = (ctrl_d_o.gate_now == POS_UP) ? ST_CLEAR : ST_CLOSED;
          end
          if (next_st != ctrl_q_i.cross_state ||
              ctrl_q_i.signal_green != !item_i.hold_trains) begin
            ctrl_d_o.cross_state  = next_st;
            ctrl_d_o.signal_green = !item_i.hold_trains;
            changed               = 1'b1;
          end
        end
        // publication
        if (changed || since_pub >= ext16(cfg_i.refresh_ticks)) begin
          seq_d_o                 = seq_q_i + {{(COUNT_W-1){1'b0}}, changed};
          last_pub_d_o            = tick_n;
          res_valid_o             = 1'b1;
          res_o.crossing_state    = ctrl_d_o.cross_state;
          res_o.gate_position     = ctrl_d_o.gate_now;
          res_o.busy_tracks       = ctrl_d_o.busy_mask;
          res_o.fault_active      = ctrl_d_o.fault_flag;
          res_o.signal_green      = ctrl_d_o.signal_green;
          res_o.line_stopped_echo = item_i.hold_trains;
          res_o.status_seq        = seq_d_o;
          res_o.served_count      = trains_d_o;
          res_o.fault_report      = report;
          res_o.state_changed     = changed;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/level_crossing_gate_controller_core.sv
// top level of the level crossing gate controller
// path: an accepted request is held in the input register, and its status, when one is published,
//   is held in the status register, which drives status_o
// throughput: one request per cycle while status_o does not stall, set by the single-pass update of the state registers
// reset: asynchronous, resets all crossing state and counters, clears valid flags and loads config reset values
`default_nettype none
module level_crossing_gate_controller_core #(
  parameter int unsigned TIME_BITS = lcgc_pkg::TIME_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lcgc_item_if.sink   item_i,
  lcgc_status_if.source status_o,
  lcgc_cfg_if.sink    cfg_i
);
  import lcgc_pkg::*;

  cfg_t                 cfg;
  logic                 inq_valid_q;
  item_t                inq_item_q;
  logic                 advance;

  ctrl_t                ctrl_q, ctrl_d;
  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic [TIME_BITS-1:0] det_time_q [2];
  logic [TIME_BITS-1:0] det_time_d [2];
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic [TIME_BITS-1:0] last_pub_q, last_pub_d;
  logic [COUNT_W-1:0]   trains_q, trains_d;
  logic [COUNT_W-1:0]   seq_q, seq_d;

  logic                 res_valid;
  status_t              res;
  logic                 out_valid_q;
  status_t              out_q;

  lcgc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance      = inq_valid_q && (!out_valid_q || status_o.ready);
  assign item_i.ready = !inq_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      inq_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      inq_item_q.opcode       <= item_i.opcode;
      inq_item_q.track_select <= item_i.track_select;
      inq_item_q.detect_stamp <= item_i.detect_stamp;
      inq_item_q.hold_trains  <= item_i.hold_trains;
    end
  end

  lcgc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item_i       (inq_item_q),
    .cfg_i        (cfg),
    .ctrl_q_i     (ctrl_q),
    .tick_q_i     (tick_q),
    .det_time_q_i (det_time_q),
    .deadline_q_i (deadline_q),
    .last_pub_q_i (last_pub_q),
    .trains_q_i   (trains_q),
    .seq_q_i      (seq_q),
    .ctrl_d_o     (ctrl_d),
    .tick_d_o     (tick_d),
    .det_time_d_o (det_time_d),
    .deadline_d_o (deadline_d),
    .last_pub_d_o (last_pub_d),
    .trains_d_o   (trains_d),
    .seq_d_o      (seq_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // crossing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.cross_state  <= ST_CLEAR;
      ctrl_q.gate_now     <= POS_UP;
      ctrl_q.gate_goal    <= 1'b0;
      ctrl_q.fault_flag   <= 1'b0;
      ctrl_q.signal_green <= 1'b1;
      ctrl_q.busy_mask    <= 2'b00;
      ctrl_q.det_valid    <= 2'b00;
      tick_q              <= '0;
      det_time_q[0]       <= '0;
      det_time_q[1]       <= '0;
      deadline_q          <= '0;
      last_pub_q          <= '0;
      trains_q            <= '0;
      seq_q               <= '0;
    end else if (advance) begin
      ctrl_q        <= ctrl_d;
      tick_q        <= tick_d;
      det_time_q[0] <= det_time_d[0];
      det_time_q[1] <= det_time_d[1];
      deadline_q    <= deadline_d;
      last_pub_q    <= last_pub_d;
      trains_q      <= trains_d;
      seq_q         <= seq_d;
    end
  end

  // status register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (status_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign status_o.valid             = out_valid_q;
  assign status_o.crossing_state    = out_q.crossing_state;
  assign status_o.gate_position     = out_q.gate_position;
  assign status_o.busy_tracks       = out_q.busy_tracks;
  assign status_o.fault_active      = out_q.fault_active;
  assign status_o.signal_green      = out_q.signal_green;
  assign status_o.line_stopped_echo = out_q.line_stopped_echo;
  assign status_o.status_seq        = out_q.status_seq;
  assign status_o.served_count      = out_q.served_count;
  assign status_o.fault_report      = out_q.fault_report;
  assign status_o.state_changed     = out_q.state_changed;

endmodule
`default_nettype wire

FILE: src/lcgc_checker.sv
// port-level checks of the controller status channel, bound to the top level
`default_nettype none
module lcgc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          st_valid,
  input wire logic                          st_ready,
  input wire logic [1:0]                    crossing_state,
  input wire logic [1:0]                    gate_position,
  input wire logic [1:0]                    busy_tracks,
  input wire logic                          fault_active,
  input wire logic                          signal_green,
  input wire logic [lcgc_pkg::COUNT_W-1:0]  status_seq,
  input wire logic                          fault_report,
  input wire logic                          state_changed
);
  import lcgc_pkg::*;

  // stalled status holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid && !st_ready |=> st_valid && $stable(status_seq) && $stable(crossing_state))
    else $error("status changed while stalled");

  // a fault report is a changed publication in the fault state
  a_fault_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid && fault_report |-> state_changed && fault_active &&
                                 crossing_state == ST_FAULT)
    else $error("fault report without fault state");

  // fault state always shows red
  a_fault_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid && crossing_state == ST_FAULT |-> !signal_green)
    else $error("green signal in fault state");

  // clear crossing has gates up and no busy track
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid && crossing_state == ST_CLEAR |-> gate_position == POS_UP && busy_tracks == 2'b00)
    else $error("clear state with gate not up or busy track");

endmodule

bind level_crossing_gate_controller_core lcgc_checker u_lcgc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .st_valid       (status_o.valid),
  .st_ready       (status_o.ready),
  .crossing_state (status_o.crossing_state),
  .gate_position  (status_o.gate_position),
  .busy_tracks    (status_o.busy_tracks),
  .fault_active   (status_o.fault_active),
  .signal_green   (status_o.signal_green),
  .status_seq     (status_o.status_seq),
  .fault_report   (status_o.fault_report),
  .state_changed  (status_o.state_changed)
);
`default_nettype wire

FILE: tb/tb_level_crossing_gate_controller_core.sv
// self-checking testbench of the level crossing gate controller with its own status predictor
`timescale 1ns / 1ps
module tb_level_crossing_gate_controller_core;
  import lcgc_pkg::*;

  logic clk_i;
  logic rst_ni;

  lcgc_item_if   item_if();
  lcgc_status_if stat_if();
  lcgc_cfg_if    cfg_if();

  level_crossing_gate_controller_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .status_o (stat_if),
    .cfg_i    (cfg_if)
  );

  // predictor copy of the configuration
  logic [CFG_W-1:0] warn_t    = WARNING_RST;
  logic [CFG_W-1:0] move_t    = MOVE_RST;
  logic [CFG_W-1:0] occupy_t  = OCCUPY_RST;
  logic [CFG_W-1:0] timeout_t = TIMEOUT_RST;
  logic [CFG_W-1:0] jam_t     = JAM_EXTRA_RST;
  logic [CFG_W-1:0] refresh_t = REFRESH_RST;

  // predictor copy of the crossing state
  logic [31:0] now_tick = '0;
  logic        det_on [2] = '{1'b0, 1'b0};
  logic [31:0] det_at [2] = '{32'd0, 32'd0};
  xstate_e     x_state   = ST_CLEAR;
  gate_pos_e   gate_at   = POS_UP;
  gate_pos_e   gate_goal = POS_UP;
  logic [31:0] move_due  = '0;
  logic        fault_on  = 1'b0;
  logic        green     = 1'b1;
  logic [1:0]  busy      = '0;
  logic [31:0] trains    = '0;
  logic [31:0] seq_count = '0;
  logic [31:0] last_pub  = '0;

  item_t   pending_reqs[$];
  status_t expected_status[$];

  int unsigned mismatches     = 0;
  int unsigned reqs_accepted  = 0;
  int unsigned status_checked = 0;
  int unsigned cfg_settings   = 0;
  int unsigned ticks_sent     = 0;
  logic        req_taken      = 1'b0;
  logic        no_gaps        = 1'b0;
  logic        line_hold      = 1'b0;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit gate_step();
    if (gate_at != POS_MOVING) return 1'b0;
    if (now_tick >= move_due) begin
      gate_at = gate_goal;
      return 1'b1;
    end
    return fault_on && (x_state != ST_FAULT);
  endfunction

  function automatic void steer_gate(gate_pos_e target);
    if (gate_goal == target) return;
    gate_goal = target;
    gate_at   = POS_MOVING;
    move_due  = sat_sum(now_tick, fault_on ? sat_sum(timeout_t, jam_t) : {16'd0, move_t});
  endfunction

  function automatic void publish(logic line, bit changed, bit report, output status_t st);
    if (changed) seq_count++;
    last_pub             = now_tick;
    st.crossing_state    = x_state;
    st.gate_position     = gate_at;
    st.busy_tracks       = busy;
    st.fault_active      = fault_on;
    st.signal_green      = green;
    st.line_stopped_echo = line;
    st.status_seq        = seq_count;
    st.served_count      = trains;
    st.fault_report      = report;
    st.state_changed     = changed;
  endfunction

  // applies one request to the predicted state, returns 1 when a status item is due
  function automatic bit crossing_update(input item_t rq, output status_t st);
    bit          changed;
    bit          coming;
    bit          lower_req;
    logic [1:0]  hit;
    logic [31:0] span;
    logic [31:0] lower;
    logic [31:0] due;
    xstate_e     nxt;
    st = '0;
    case (rq.opcode)
      OP_DETECT: begin
        det_on[rq.track_select] = 1'b1;
        det_at[rq.track_select] = rq.detect_stamp;
        return 1'b0;
      end
      OP_FAULT_SET: begin
        fault_on = 1'b1;
        return 1'b0;
      end
      OP_FAULT_CLR: begin
        fault_on = 1'b0;
        return 1'b0;
      end
      default: ;
    endcase
    now_tick++;
    changed = gate_step();
    if (fault_on) begin
      if (x_state != ST_FAULT) begin
        x_state = ST_FAULT;
        green   = 1'b0;
        publish(rq.hold_trains, 1'b1, 1'b1, st);
        return 1'b1;
      end
    end else begin
      coming    = 1'b0;
      lower_req = 1'b0;
      hit       = '0;
      span      = sat_sum(sat_sum(warn_t, move_t), occupy_t);
      for (int t = 0; t < 2; t++) begin
        if (det_on[t]) begin
          if (now_tick >= sat_sum(det_at[t], span)) begin
            det_on[t] = 1'b0;
            changed   = 1'b1;
          end else begin
            coming = 1'b1;
            lower  = sat_sum(det_at[t], warn_t);
            due    = sat_sum(lower, move_t);
            if (now_tick >= lower) lower_req = 1'b1;
            if (now_tick >= due && gate_at == POS_DOWN) begin
              if (!busy[t]) trains++;
              hit[t] = 1'b1;
            end
          end
        end
      end
      if (hit != busy) begin
        busy    = hit;
        changed = 1'b1;
      end
      if (lower_req || (coming && gate_goal == POS_DOWN)) begin
        steer_gate(POS_DOWN);
      end else if (!coming) begin
        steer_gate(POS_UP);
      end
      if (coming) begin
        if (gate_at == POS_DOWN) nxt = ST_CLOSED;
        else nxt = ST_WARNING;
      end else begin
        if (gate_at == POS_UP) nxt = ST_CLEAR;
        else nxt = ST_CLOSED;
      end
      if (nxt != x_state || green != ~rq.hold_trains) begin
        x_state = nxt;
        green   = ~rq.hold_trains;
        changed = 1'b1;
      end
    end
    if (!changed && (now_tick - last_pub) < {16'd0, refresh_t}) return 1'b0;
    publish(rq.hold_trains, changed, 1'b0, st);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // request driver
  always @(negedge clk_i) begin : feed
    item_t nx;
    if (!item_if.valid || req_taken) begin
      if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 38)) begin
        nx = pending_reqs.pop_front();
        item_if.opcode       <= nx.opcode;
        item_if.track_select <= nx.track_select;
        item_if.detect_stamp <= nx.detect_stamp;
        item_if.hold_trains  <= nx.hold_trains;
        item_if.valid        <= 1'b1;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    stat_if.ready <= no_gaps || ($urandom_range(0, 99) >= 38);
  end

  // status check and request prediction
  always @(posedge clk_i) begin : watch
    status_t want;
    status_t pred;
    item_t   rq;
    req_taken <= item_if.valid && item_if.ready;
    if (rst_ni) begin
      if (stat_if.valid && stat_if.ready) begin
        status_checked++;
        if (expected_status.size() == 0) begin
          $error("status item with no request pending it");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("crossing_state", want.crossing_state, stat_if.crossing_state);
          check_field("gate_position", want.gate_position, stat_if.gate_position);
          check_field("busy_tracks", want.busy_tracks, stat_if.busy_tracks);
          check_field("fault_active", want.fault_active, stat_if.fault_active);
          check_field("signal_green", want.signal_green, stat_if.signal_green);
          check_field("line_stopped_echo", want.line_stopped_echo,
                      stat_if.line_stopped_echo);
          check_field("status_seq", want.status_seq, stat_if.status_seq);
          check_field("served_count", want.served_count, stat_if.served_count);
          check_field("fault_report", want.fault_report, stat_if.fault_report);
          check_field("state_changed", want.state_changed, stat_if.state_changed);
        end
      end
      if (item_if.valid && item_if.ready) begin
        reqs_accepted++;
        rq.opcode       = item_if.opcode;
        rq.track_select = item_if.track_select;
        rq.detect_stamp = item_if.detect_stamp;
        rq.hold_trains  = item_if.hold_trains;
        if (crossing_update(rq, pred)) expected_status.push_back(pred);
      end
    end
  end

  function automatic void push_req(opcode_e op, logic trk, logic [31:0] stamp, logic line);
    item_t rq;
    rq.opcode       = op;
    rq.track_select = trk;
    rq.detect_stamp = stamp;
    rq.hold_trains  = line;
    pending_reqs.push_back(rq);
    if (op == OP_TICK) ticks_sent++;
  endfunction

  task automatic drain();
    int unsigned waited;
    while (pending_reqs.size() != 0 || item_if.valid) @(posedge clk_i);
    waited = 0;
    while (expected_status.size() != 0 && waited < 3000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_status.size() != 0) begin
      $error("%0d expected status items never arrived", expected_status.size());
      mismatches++;
      expected_status.delete();
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_WARNING:   warn_t    = val;
      CFG_MOVE:      move_t    = val;
      CFG_OCCUPY:    occupy_t  = val;
      CFG_TIMEOUT:   timeout_t = val;
      CFG_JAM_EXTRA: jam_t     = val;
      CFG_REFRESH:   refresh_t = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(int unsigned w, int unsigned m, int unsigned o,
                            int unsigned t, int unsigned j, int unsigned r);
    drain();
    write_reg(CFG_WARNING, w[15:0]);
    write_reg(CFG_MOVE, m[15:0]);
    write_reg(CFG_OCCUPY, o[15:0]);
    write_reg(CFG_TIMEOUT, t[15:0]);
    write_reg(CFG_JAM_EXTRA, j[15:0]);
    write_reg(CFG_REFRESH, r[15:0]);
    cfg_settings++;
  endtask

  task automatic run_phase(int unsigned n, int unsigned pause_at);
    int unsigned pushed;
    int unsigned r;
    int unsigned k;
    int unsigned lim;
    logic [31:0] stamp;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        k = $urandom_range(0, 99);
        lim = warn_t + move_t + occupy_t;
        if (lim > 400) lim = 400;
        if (k < 60) stamp = ticks_sent + $urandom_range(0, 4) - 32'd2;
        else if (k < 85) stamp = ticks_sent - $urandom_range(0, lim);
        else stamp = $urandom;
        push_req(OP_DETECT, $urandom_range(0, 1), stamp, $urandom_range(0, 1));
        pushed++;
      end else if (r < 14) begin
        k = $urandom_range(0, 6);
        push_req(OP_FAULT_SET, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
        repeat (k) push_req(OP_TICK, $urandom_range(0, 1), $urandom, line_hold);
        push_req(OP_FAULT_CLR, $urandom_range(0, 1), $urandom, $urandom_range(0, 1));
        pushed += k + 2;
      end else if (r < 17) begin
        push_req(opcode_e'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom,
                 $urandom_range(0, 1));
        pushed++;
      end else begin
        if ($urandom_range(0, 99) < 6) line_hold = ~line_hold;
        push_req(OP_TICK, $urandom_range(0, 1), $urandom, line_hold);
        pushed++;
      end
      if (pause_at != 0 && pushed >= pause_at && pushed < pause_at + 8) begin
        drain();
        pause_at = 0;
      end
    end
  endtask

  initial begin
    item_if.valid        = 1'b0;
    item_if.opcode       = OP_TICK;
    item_if.track_select = 1'b0;
    item_if.detect_stamp = '0;
    item_if.hold_trains  = 1'b0;
    stat_if.ready        = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = CFG_WARNING;
    cfg_if.data          = '0;
    rst_ni               = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: line stop, two trains, fault episode, stamp extremes
    set_config(3, 2, 3, 2, 1, 4);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_TICK, 1'b1, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b1);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_DETECT, 1'b0, ticks_sent, 1'b0);
    push_req(OP_DETECT, 1'b1, ticks_sent + 3, 1'b1);
    repeat (7) push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_FAULT_SET, 1'b0, 32'd0, 1'b0);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b1);
    push_req(OP_FAULT_CLR, 1'b1, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_DETECT, 1'b0, 32'd0, 1'b0);
    push_req(OP_DETECT, 1'b1, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b0);
    push_req(OP_TICK, 1'b0, 32'd0, 1'b1);

    // random phases over several settings
    set_config(WARNING_RST, MOVE_RST, OCCUPY_RST, TIMEOUT_RST, JAM_EXTRA_RST, REFRESH_RST);
    run_phase(100, 0);
    set_config(1, 1, 1, 1, 0, 1);
    run_phase(150, 0);
    set_config(65535, 65535, 65535, 65535, 65535, 65535);
    run_phase(80, 0);
    for (int p = 0; p < 4; p++) begin
      set_config($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1, 10),
                 $urandom_range(1, 8), $urandom_range(0, 6), $urandom_range(1, 25));
      no_gaps = (p == 1);
      run_phase(170, (p == 2) ? 85 : 0);
    end
    no_gaps = 1'b0;
    set_config(1, 1, 65535, 65535, 65535, 1);
    run_phase(120, 0);

    drain();
    repeat (10) @(posedge clk_i);
    $display("run covered %0d requests over %0d ticks and %0d register settings, %0d status checked",
             reqs_accepted, ticks_sent, cfg_settings, status_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
